// File: hw/rtl/sd_spi_command_engine_core_macros.svh
// Assertion helpers used by the command engine core.
`ifndef SD_SPI_COMMAND_ENGINE_CORE_MACROS_SVH
`define SD_SPI_COMMAND_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SDSPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SDSPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sdspi_pkg.sv
package sdspi_pkg;

  typedef logic [5:0]  cmd_t;
  typedef logic [31:0] arg_t;
  typedef logic [7:0]  byte_t;
  typedef logic [6:0]  crc_t;
  typedef logic [15:0] poll_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BUSY_TO  = 2'd1,
    ST_RESP_TO  = 2'd2,
    ST_READY_TO = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_BUSY_LIMIT  = 2'd0,
    CFG_RESP_LIMIT  = 2'd1,
    CFG_READY_LIMIT = 2'd2
  } cfg_idx_t;

  localparam int CfgDataW = 16;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_RX    = 1'b1;
  localparam logic KIND_SEND  = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  localparam byte_t BYTE_IDLE  = 8'hFF;
  localparam byte_t START_BITS = 8'h40;
  localparam crc_t  CRC7_POLY  = 7'h09;

  localparam cmd_t CMD_STOP      = 6'd12;
  localparam cmd_t CMD_READ_ONE  = 6'd17;
  localparam cmd_t CMD_READ_MANY = 6'd18;
  localparam cmd_t CMD_WRITE_ONE = 6'd24;

  localparam logic [15:0] BUSY_LIMIT_RST  = 16'd300;
  localparam logic [7:0]  RESP_LIMIT_RST  = 8'd20;
  localparam logic [15:0] READY_LIMIT_RST = 16'd20000;

  function automatic crc_t crc7_byte(input crc_t crc, input byte_t b);
    crc_t c;
    logic fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[6] ^ b[i];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ CRC7_POLY;
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/sdspi_if.sv
interface sdspi_in_if import sdspi_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  mode;
  cmd_t  cmd_index;
  arg_t  argument;
  byte_t rx_byte;

  modport source(output valid, mode, cmd_index, argument, rx_byte, input ready);
  modport sink(input valid, mode, cmd_index, argument, rx_byte, output ready);
endinterface

interface sdspi_out_if import sdspi_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    kind;
  byte_t   tx_byte;
  logic    select_active;
  byte_t   reply;
  status_t status;

  modport source(output valid, kind, tx_byte, select_active, reply, status, input ready);
  modport sink(input valid, kind, tx_byte, select_active, reply, status, output ready);
endinterface

// File: hw/rtl/sd_spi_command_engine_core.sv
// An accepted input transaction is held in the input register; the single step logic between
// it and the result register computes its result. A received byte while idle produces no result.
// Throughput: one transaction per cycle unless out_ch.ready low stalls the result register.
// Reset (synchronous, rst_n low): engine idle, chip select released, limits 300/20/20000.
`include "sd_spi_command_engine_core_macros.svh"

module sd_spi_command_engine_core import sdspi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  sdspi_in_if.sink            in_ch,
  sdspi_out_if.source         out_ch,
  input  logic                cfg_we,
  input  cfg_idx_t            cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_LEAD     = 4'd1,
    PH_DUMMY    = 4'd2,
    PH_BUSY     = 4'd3,
    PH_FRAME    = 4'd4,
    PH_STUFF    = 4'd5,
    PH_RESP     = 4'd6,
    PH_READY    = 4'd7,
    PH_TRAIL_OK = 4'd8,
    PH_TRAIL_TO = 4'd9
  } phase_t;

  logic [15:0] busy_lim_r;
  logic [7:0]  resp_lim_r;
  logic [15:0] ready_lim_r;

  logic  in_q_valid_r;
  logic  in_q_mode_r;
  cmd_t  in_q_cmd_r;
  arg_t  in_q_arg_r;
  byte_t in_q_rx_r;

  phase_t     phase_r, phase_nxt;
  cmd_t       cmd_r, cmd_nxt;
  arg_t       arg_r, arg_nxt;
  crc_t       crc_r, crc_nxt;
  logic [2:0] fbc_r, fbc_nxt;
  poll_t      poll_r, poll_nxt;
  byte_t      held_r, held_nxt;
  logic       sel_r, sel_nxt;

  logic    out_valid_r;
  logic    out_kind_r;
  byte_t   out_tx_r;
  logic    out_sel_r;
  byte_t   out_reply_r;
  status_t out_status_r;

  logic    proc_fire;
  logic    res_valid;
  logic    res_kind;
  byte_t   res_tx;
  logic    res_sel;
  byte_t   res_reply;
  status_t res_status;

  logic    do_frame, do_resp, do_timeout, do_finish, do_done;
  status_t done_status;
  byte_t   frame_b;
  crc_t    frame_crc;
  logic    keep_sel;

  logic    done_fire;
  logic    timeout_out;

  assign proc_fire   = in_q_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_q_valid_r || proc_fire;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_kind_r;
  assign out_ch.tx_byte       = out_tx_r;
  assign out_ch.select_active = out_sel_r;
  assign out_ch.reply         = out_reply_r;
  assign out_ch.status        = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_lim_r  <= BUSY_LIMIT_RST;
      resp_lim_r  <= RESP_LIMIT_RST;
      ready_lim_r <= READY_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUSY_LIMIT:  busy_lim_r  <= cfg_wdata;
        CFG_RESP_LIMIT:  resp_lim_r  <= cfg_wdata[7:0];
        CFG_READY_LIMIT: ready_lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_q_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_q_mode_r <= in_ch.mode;
      in_q_cmd_r  <= in_ch.cmd_index;
      in_q_arg_r  <= in_ch.argument;
      in_q_rx_r   <= in_ch.rx_byte;
    end
  end

  always_comb begin
    unique case (fbc_r)
      3'd0:    frame_b = START_BITS | {2'b00, cmd_r};
      3'd1:    frame_b = arg_r[31:24];
      3'd2:    frame_b = arg_r[23:16];
      3'd3:    frame_b = arg_r[15:8];
      3'd4:    frame_b = arg_r[7:0];
      default: frame_b = {crc_r, 1'b1};
    endcase
    frame_crc = (fbc_r < 3'd5) ? crc7_byte(crc_r, frame_b) : crc_r;
  end

  assign keep_sel = (cmd_r == CMD_READ_ONE) || (cmd_r == CMD_READ_MANY) ||
                    (cmd_r == CMD_WRITE_ONE);

  always_comb begin
    phase_nxt   = phase_r;
    cmd_nxt     = cmd_r;
    arg_nxt     = arg_r;
    crc_nxt     = crc_r;
    fbc_nxt     = fbc_r;
    poll_nxt    = poll_r;
    held_nxt    = held_r;
    sel_nxt     = sel_r;
    res_valid   = 1'b1;
    res_kind    = KIND_SEND;
    res_tx      = BYTE_IDLE;
    res_status  = ST_OK;
    do_frame    = 1'b0;
    do_resp     = 1'b0;
    do_timeout  = 1'b0;
    do_finish   = 1'b0;
    do_done     = 1'b0;
    done_status = ST_OK;

    if (in_q_mode_r == MODE_START) begin
      cmd_nxt   = in_q_cmd_r;
      arg_nxt   = in_q_arg_r;
      crc_nxt   = '0;
      fbc_nxt   = '0;
      poll_nxt  = '0;
      held_nxt  = BYTE_IDLE;
      sel_nxt   = 1'b1;
      phase_nxt = PH_LEAD;
    end else begin
      unique case (phase_r)
        PH_LEAD: begin
          if (cmd_r == CMD_STOP) begin
            do_frame = 1'b1;
          end else begin
            phase_nxt = PH_DUMMY;
          end
        end
        PH_DUMMY: begin
          if (busy_lim_r == '0) begin
            do_done     = 1'b1;
            done_status = ST_BUSY_TO;
          end else begin
            poll_nxt  = 16'd1;
            phase_nxt = PH_BUSY;
          end
        end
        PH_BUSY: begin
          if (in_q_rx_r == BYTE_IDLE) begin
            do_frame = 1'b1;
          end else if (poll_r >= busy_lim_r) begin
            do_done     = 1'b1;
            done_status = ST_BUSY_TO;
          end else begin
            poll_nxt = poll_r + 16'd1;
          end
        end
        PH_FRAME: begin
          if (fbc_r < 3'd6) begin
            do_frame = 1'b1;
          end else if (cmd_r == CMD_STOP) begin
            phase_nxt = PH_STUFF;
          end else begin
            do_resp = 1'b1;
          end
        end
        PH_STUFF: do_resp = 1'b1;
        PH_RESP: begin
          if (!in_q_rx_r[7]) begin
            held_nxt = in_q_rx_r;
            if (cmd_r == CMD_STOP) begin
              poll_nxt  = '0;
              phase_nxt = PH_READY;
            end else begin
              do_finish = 1'b1;
            end
          end else if (poll_r >= {8'd0, resp_lim_r}) begin
            do_timeout = 1'b1;
          end else begin
            poll_nxt = poll_r + 16'd1;
          end
        end
        PH_READY: begin
          if (in_q_rx_r == BYTE_IDLE) begin
            do_finish = 1'b1;
          end else if (poll_r >= ready_lim_r) begin
            held_nxt    = BYTE_IDLE;
            do_done     = 1'b1;
            done_status = ST_READY_TO;
          end else begin
            poll_nxt = poll_r + 16'd1;
          end
        end
        PH_TRAIL_OK: begin
          do_done     = 1'b1;
          done_status = ST_OK;
        end
        PH_TRAIL_TO: begin
          do_done     = 1'b1;
          done_status = ST_RESP_TO;
        end
        PH_IDLE: res_valid = 1'b0;
        default: begin
          res_valid = 1'b0;
          phase_nxt = PH_IDLE;
        end
      endcase
    end

    if (do_frame) begin
      res_tx    = frame_b;
      crc_nxt   = frame_crc;
      fbc_nxt   = fbc_r + 3'd1;
      phase_nxt = PH_FRAME;
    end
    if (do_resp) begin
      if (resp_lim_r == '0) begin
        do_timeout = 1'b1;
      end else begin
        poll_nxt  = 16'd1;
        phase_nxt = PH_RESP;
      end
    end
    if (do_timeout) begin
      held_nxt  = BYTE_IDLE;
      sel_nxt   = 1'b0;
      phase_nxt = PH_TRAIL_TO;
    end
    if (do_finish) begin
      if (keep_sel) begin
        do_done     = 1'b1;
        done_status = ST_OK;
      end else begin
        sel_nxt   = 1'b0;
        phase_nxt = PH_TRAIL_OK;
      end
    end
    if (do_done) begin
      res_kind   = KIND_DONE;
      res_tx     = '0;
      res_status = done_status;
      phase_nxt  = PH_IDLE;
    end

    res_reply = !do_done ? 8'd0 : ((done_status == ST_OK) ? held_nxt : BYTE_IDLE);
    res_sel   = (in_q_mode_r == MODE_START) ? sel_r : sel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      cmd_r        <= '0;
      arg_r        <= '0;
      crc_r        <= '0;
      fbc_r        <= '0;
      poll_r       <= '0;
      held_r       <= BYTE_IDLE;
      sel_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      out_kind_r   <= KIND_SEND;
      out_tx_r     <= '0;
      out_sel_r    <= 1'b0;
      out_reply_r  <= '0;
      out_status_r <= ST_OK;
    end else begin
      if (proc_fire) begin
        phase_r     <= phase_nxt;
        cmd_r       <= cmd_nxt;
        arg_r       <= arg_nxt;
        crc_r       <= crc_nxt;
        fbc_r       <= fbc_nxt;
        poll_r      <= poll_nxt;
        held_r      <= held_nxt;
        sel_r       <= sel_nxt;
        out_valid_r <= res_valid;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (proc_fire && res_valid) begin
        out_kind_r   <= res_kind;
        out_tx_r     <= res_tx;
        out_sel_r    <= res_sel;
        out_reply_r  <= res_reply;
        out_status_r <= res_status;
      end
    end
  end

  assign done_fire   = proc_fire && res_valid && (res_kind == KIND_DONE);
  assign timeout_out = out_valid_r && (out_status_r != ST_OK);

  `SDSPI_ASSERT_NOW(a_fbc, phase_r == PH_FRAME, fbc_r != 3'd0 && fbc_r != 3'd7, "bad frame count")
  `SDSPI_ASSERT_NEXT(a_done_idle, done_fire, phase_r == PH_IDLE, "engine not idle after done")
  `SDSPI_ASSERT_NOW(a_timeout_reply, timeout_out, out_reply_r == BYTE_IDLE, "timeout reply not 0xFF")
  `SDSPI_ASSERT_NEXT(a_inq_holds, in_q_valid_r && !proc_fire, in_q_valid_r, "pending input lost")

endmodule

// File: test/sdspi_exchange_checker.sv
`timescale 1ns / 100ps

module sdspi_exchange_checker import sdspi_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  sdspi_in_if                 in_ch,
  sdspi_out_if                out_ch,
  input  logic                cfg_we,
  input  cfg_idx_t            cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int                  fail_count,
  output int                  pending,
  output int                  compared
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEAD,
    S_DUMMY,
    S_BUSY_POLL,
    S_FRAME,
    S_STUFF,
    S_RESP_POLL,
    S_READY_POLL,
    S_TAIL_OK,
    S_TAIL_TIMEOUT
  } engine_phase_t;

  typedef struct packed {
    logic    kind;
    byte_t   tx;
    logic    sel;
    byte_t   reply;
    status_t status;
  } exchange_t;

  logic [15:0]   busy_limit;
  logic [7:0]    resp_limit;
  logic [15:0]   ready_limit;
  engine_phase_t phase;
  cmd_t          cur_cmd;
  arg_t          cur_arg;
  crc_t          crc;
  logic [2:0]    frame_idx;
  poll_t         polls;
  byte_t         first_reply;
  logic          cs_low;
  int            errors;
  int            matched;
  exchange_t     expected_exchanges[$];

  function automatic crc_t crc7_add(input crc_t c, input byte_t b);
    for (int k = 7; k >= 0; k--) begin
      if (c[6] ^ b[k]) begin
        c = {c[5:0], 1'b0} ^ CRC7_POLY;
      end else begin
        c = {c[5:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic exchange_t send_byte(input byte_t b);
    return '{kind: KIND_SEND, tx: b, sel: cs_low, reply: 8'h00, status: ST_OK};
  endfunction

  function automatic exchange_t finish_cmd(input status_t st);
    exchange_t r;
    r = '{kind: KIND_DONE, tx: 8'h00, sel: cs_low,
          reply: (st == ST_OK) ? first_reply : BYTE_IDLE, status: st};
    phase = S_IDLE;
    return r;
  endfunction

  function automatic exchange_t frame_byte();
    byte_t b;
    case (frame_idx)
      3'd0: b = START_BITS | {2'b00, cur_cmd};
      3'd1: b = cur_arg[31:24];
      3'd2: b = cur_arg[23:16];
      3'd3: b = cur_arg[15:8];
      3'd4: b = cur_arg[7:0];
      default: b = {crc, 1'b1};
    endcase
    if (frame_idx < 3'd5) begin
      crc = crc7_add(crc, b);
    end
    frame_idx = frame_idx + 3'd1;
    phase = S_FRAME;
    return send_byte(b);
  endfunction

  function automatic exchange_t resp_timeout();
    first_reply = BYTE_IDLE;
    cs_low = 1'b0;
    phase = S_TAIL_TIMEOUT;
    return send_byte(BYTE_IDLE);
  endfunction

  function automatic exchange_t resp_start();
    if (resp_limit == 8'd0) begin
      return resp_timeout();
    end
    polls = 16'd1;
    phase = S_RESP_POLL;
    return send_byte(BYTE_IDLE);
  endfunction

  // Reads and single-block writes keep the card selected; everything else releases it.
  function automatic exchange_t wrap_up();
    if (cur_cmd inside {CMD_READ_ONE, CMD_READ_MANY, CMD_WRITE_ONE}) begin
      return finish_cmd(ST_OK);
    end
    cs_low = 1'b0;
    phase = S_TAIL_OK;
    return send_byte(BYTE_IDLE);
  endfunction

  function automatic logic predict_exchange(input logic mode, input cmd_t cmd,
                                            input arg_t arg, input byte_t rx,
                                            output exchange_t r);
    r = '0;
    if (mode == MODE_START) begin
      cur_cmd = cmd;
      cur_arg = arg;
      crc = '0;
      frame_idx = '0;
      polls = '0;
      first_reply = BYTE_IDLE;
      r = send_byte(BYTE_IDLE);
      cs_low = 1'b1;
      phase = S_LEAD;
      return 1'b1;
    end
    case (phase)
      S_LEAD: begin
        if (cur_cmd == CMD_STOP) begin
          r = frame_byte();
        end else begin
          phase = S_DUMMY;
          r = send_byte(BYTE_IDLE);
        end
      end
      S_DUMMY: begin
        if (busy_limit == 16'd0) begin
          r = finish_cmd(ST_BUSY_TO);
        end else begin
          polls = 16'd1;
          phase = S_BUSY_POLL;
          r = send_byte(BYTE_IDLE);
        end
      end
      S_BUSY_POLL: begin
        if (rx == BYTE_IDLE) begin
          r = frame_byte();
        end else if (polls >= busy_limit) begin
          r = finish_cmd(ST_BUSY_TO);
        end else begin
          polls = polls + 16'd1;
          r = send_byte(BYTE_IDLE);
        end
      end
      S_FRAME: begin
        if (frame_idx < 3'd6) begin
          r = frame_byte();
        end else if (cur_cmd == CMD_STOP) begin
          phase = S_STUFF;
          r = send_byte(BYTE_IDLE);
        end else begin
          r = resp_start();
        end
      end
      S_STUFF: begin
        r = resp_start();
      end
      S_RESP_POLL: begin
        if (!rx[7]) begin
          first_reply = rx;
          if (cur_cmd == CMD_STOP) begin
            polls = '0;
            phase = S_READY_POLL;
            r = send_byte(BYTE_IDLE);
          end else begin
            r = wrap_up();
          end
        end else if (polls >= {8'h00, resp_limit}) begin
          r = resp_timeout();
        end else begin
          polls = polls + 16'd1;
          r = send_byte(BYTE_IDLE);
        end
      end
      S_READY_POLL: begin
        if (rx == BYTE_IDLE) begin
          r = wrap_up();
        end else if (polls >= ready_limit) begin
          first_reply = BYTE_IDLE;
          r = finish_cmd(ST_READY_TO);
        end else begin
          polls = polls + 16'd1;
          r = send_byte(BYTE_IDLE);
        end
      end
      S_TAIL_OK: begin
        r = finish_cmd(ST_OK);
      end
      S_TAIL_TIMEOUT: begin
        r = finish_cmd(ST_RESP_TO);
      end
      default: begin
        phase = S_IDLE;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    exchange_t got;
    exchange_t want;
    exchange_t next;
    if (!rst_n) begin
      busy_limit = BUSY_LIMIT_RST;
      resp_limit = RESP_LIMIT_RST;
      ready_limit = READY_LIMIT_RST;
      phase = S_IDLE;
      cur_cmd = '0;
      cur_arg = '0;
      crc = '0;
      frame_idx = '0;
      polls = '0;
      first_reply = BYTE_IDLE;
      cs_low = 1'b0;
      expected_exchanges.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BUSY_LIMIT:  busy_limit = cfg_wdata;
          CFG_RESP_LIMIT:  resp_limit = cfg_wdata[7:0];
          CFG_READY_LIMIT: ready_limit = cfg_wdata;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{kind: out_ch.kind, tx: out_ch.tx_byte, sel: out_ch.select_active,
                reply: out_ch.reply, status: out_ch.status};
        if (expected_exchanges.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, actual kind %0d tx %0h reply %0h",
                   $time, got.kind, got.tx, got.reply);
        end else begin
          want = expected_exchanges.pop_front();
          matched++;
          check_field("kind", {7'd0, want.kind}, {7'd0, got.kind});
          check_field("tx_byte", want.tx, got.tx);
          check_field("select_active", {7'd0, want.sel}, {7'd0, got.sel});
          check_field("reply", want.reply, got.reply);
          check_field("status", {6'd0, want.status}, {6'd0, got.status});
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (predict_exchange(in_ch.mode, in_ch.cmd_index, in_ch.argument, in_ch.rx_byte,
                             next)) begin
          expected_exchanges.push_back(next);
        end
      end
    end
    fail_count <= errors;
    compared <= matched;
    pending <= expected_exchanges.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import sdspi_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_t            cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  fail_count;
  int                  pending;
  int                  compared;
  int                  items_sent;
  int                  commands_sent;
  int                  rx_budget;
  logic [15:0]         busy_lim;
  logic [7:0]          resp_lim;
  logic [15:0]         ready_lim;

  sdspi_in_if  in_ch();
  sdspi_out_if out_ch();

  sd_spi_command_engine_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sdspi_exchange_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .compared   (compared)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("sd_spi_command_engine_core test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic byte_t any_byte();
    return byte_t'($urandom_range(255));
  endfunction

  function automatic byte_t not_idle();
    return byte_t'($urandom_range(254));
  endfunction

  function automatic byte_t busy_resp();
    return byte_t'(8'h80 | $urandom_range(127));
  endfunction

  function automatic byte_t good_resp();
    return byte_t'($urandom_range(127));
  endfunction

  function automatic int pick_wait(input int limit);
    if (limit <= 12) begin
      return $urandom_range(limit + 1);
    end
    return ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(2);
  endfunction

  task automatic put(input logic mode, input cmd_t cmd, input arg_t arg, input byte_t rx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.cmd_index <= cmd;
    in_ch.argument <= arg;
    in_ch.rx_byte <= rx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // A cut-short command stops sending card bytes once its budget runs out.
  task automatic put_rx(input byte_t rx);
    if (rx_budget == 0) begin
      return;
    end
    rx_budget--;
    put(MODE_RX, cmd_t'($urandom_range(63)), $urandom, rx);
  endtask

  task automatic run_command(input cmd_t cmd, input arg_t arg, input int busy_n,
                             input int resp_n, input int ready_n, input byte_t answer);
    put(MODE_START, cmd, arg, any_byte());
    commands_sent++;
    put_rx(any_byte());
    if (cmd != CMD_STOP) begin
      put_rx(any_byte());
      if (busy_lim == 16'd0) begin
        return;
      end
      for (int i = 1; i <= busy_n; i++) begin
        put_rx(not_idle());
        if (i >= busy_lim) begin
          return;
        end
      end
      put_rx(BYTE_IDLE);
    end
    repeat (6) put_rx(any_byte());
    if (cmd == CMD_STOP) begin
      put_rx(any_byte());
    end
    if (resp_lim == 8'd0) begin
      put_rx(any_byte());
      return;
    end
    for (int i = 1; i <= resp_n; i++) begin
      put_rx(busy_resp());
      if (i >= resp_lim) begin
        put_rx(any_byte());
        return;
      end
    end
    put_rx(answer);
    if (cmd == CMD_STOP) begin
      for (int i = 0; i < ready_n; i++) begin
        put_rx(not_idle());
        if (i >= ready_lim) begin
          return;
        end
      end
      put_rx(BYTE_IDLE);
    end
    if (!(cmd inside {CMD_READ_ONE, CMD_READ_MANY, CMD_WRITE_ONE})) begin
      put_rx(any_byte());
    end
  endtask

  task automatic random_command();
    cmd_t cmd;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      cmd = CMD_STOP;
    end else if (pick < 35) begin
      cmd = CMD_READ_ONE;
    end else if (pick < 45) begin
      cmd = CMD_READ_MANY;
    end else if (pick < 55) begin
      cmd = CMD_WRITE_ONE;
    end else begin
      cmd = cmd_t'($urandom_range(63));
    end
    rx_budget = ($urandom_range(7) == 0) ? $urandom_range(14) : 1_000_000;
    run_command(cmd, $urandom, pick_wait(busy_lim), pick_wait(resp_lim),
                pick_wait(ready_lim), good_resp());
    rx_budget = 1_000_000;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        put(MODE_RX, cmd_t'($urandom_range(63)), $urandom, any_byte());
      end
    end
  endtask

  task automatic apply_limits(input logic [15:0] busy, input logic [7:0] resp,
                              input logic [15:0] ready);
    logic [7:0] junk;
    junk = 8'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BUSY_LIMIT;
    cfg_wdata <= busy;
    @(posedge clk);
    cfg_index <= CFG_RESP_LIMIT;
    cfg_wdata <= {junk, resp};
    @(posedge clk);
    cfg_index <= CFG_READY_LIMIT;
    cfg_wdata <= ready;
    @(posedge clk);
    cfg_we <= 1'b0;
    busy_lim = busy;
    resp_lim = resp;
    ready_lim = ready;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int first_item;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_RX;
    in_ch.cmd_index = '0;
    in_ch.argument = '0;
    in_ch.rx_byte = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_BUSY_LIMIT;
    cfg_wdata = '0;
    rst_n = 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 51;
    busy_lim = BUSY_LIMIT_RST;
    resp_lim = RESP_LIMIT_RST;
    ready_lim = READY_LIMIT_RST;
    rx_budget = 1_000_000;
    items_sent = 0;
    commands_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    put(MODE_RX, '0, '0, BYTE_IDLE);
    run_command(CMD_READ_ONE, 32'h0000_0000, 0, 0, 0, 8'h00);
    run_command(CMD_STOP, 32'hFFFF_FFFF, 0, 1, 1, 8'h7F);
    run_command(6'd63, 32'h8000_0001, 2, 2, 0, 8'h01);
    settle();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 17;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 17;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 3; s++) begin
        case (p * 3 + s)
          0: apply_limits(BUSY_LIMIT_RST, RESP_LIMIT_RST, READY_LIMIT_RST);
          1: apply_limits(16'd0, 8'd0, 16'd0);
          2: apply_limits(16'd65535, 8'd255, 16'd65535);
          3: apply_limits(16'd1, 8'd1, 16'd1);
          4: apply_limits(16'd4, 8'd3, 16'd2);
          5: apply_limits(16'd2, 8'd6, 16'd5);
          6: apply_limits(16'd8, 8'd2, 16'd3);
          7: apply_limits(16'd1, 8'd255, 16'd4);
          default: apply_limits(16'd3, 8'd1, 16'd65535);
        endcase
        first_item = items_sent;
        while (items_sent - first_item < 140) random_command();
        settle();
      end
    end

    $display("Ran %0d commands in %0d input transactions and compared %0d results,",
             commands_sent, items_sent, compared);
    $display("over nine sets of poll limits and three flow-control patterns.");
    if (fail_count == 0) begin
      $display("sd_spi_command_engine_core test passed");
    end else begin
      $display("sd_spi_command_engine_core test failed");
    end
    $finish;
  end

endmodule
